// ===== hdl/jse_pkg.sv =====
package jse_pkg;

   localparam int MAX_SIZE     = 8;
   localparam int WORD_BITS    = 32;
   localparam int FRAC_BITS    = 24;
   localparam int STORE_DEPTH  = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
   localparam int CORDIC_STEPS = 30;
   localparam int ROOT_STEPS   = 28;
   localparam int MUL_BITS     = 33;
   localparam int TERM_BITS    = 35;
   localparam int ACC_BITS     = 36;
   localparam int ANG_BITS     = 35;

   localparam logic signed [ANG_BITS-1:0] ANGLE_PI         = 35'sd3373259426;
   localparam logic signed [ANG_BITS-1:0] ANGLE_QUARTER_PI = 35'sd843314857;
   localparam logic signed [ACC_BITS-1:0] CORDIC_GAIN_INV  = 36'sd652032874;
   localparam logic signed [WORD_BITS-1:0] WORD_ONE = 32'sd1 <<< FRAC_BITS;

   localparam logic [1:0] CSR_ACTIVE_SIZE    = 2'd0;
   localparam logic [1:0] CSR_ROTATION_LIMIT = 2'd1;
   localparam logic [1:0] CSR_STOP_LEVEL     = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_COPY, ST_SRCH_INIT, ST_SRCH_RD, ST_SRCH_CMP, ST_DECIDE,
      ST_PIV_RD, ST_PIV_DEC, ST_VECTOR, ST_ROTATE, ST_MAC, ST_DIAG_WR,
      ST_OFF_NEXT, ST_OFF_RD, ST_OFF_WR, ST_VEC_NEXT, ST_VEC_RD, ST_VEC_WR,
      ST_ROOT_RD, ST_ROOT_RUN, ST_OUT_RD, ST_OUT_SEND
   } state_type;

   typedef enum logic [1:0] {
      PH_COEF, PH_DIAG, PH_OFF, PH_VEC
   } phase_type;

   function automatic logic signed [ANG_BITS-1:0] atan_step(input logic [4:0] i);
      logic signed [ANG_BITS-1:0] r;
      case (i)
         5'd0: r = 35'sd843314857;
         5'd1: r = 35'sd497837829;
         5'd2: r = 35'sd263043837;
         5'd3: r = 35'sd133525159;
         5'd4: r = 35'sd67021687;
         5'd5: r = 35'sd33543516;
         5'd6: r = 35'sd16775851;
         5'd7: r = 35'sd8388437;
         5'd8: r = 35'sd4194283;
         5'd9: r = 35'sd2097149;
         default: r = 35'sd1 <<< (5'd30 - i);
      endcase
      return r;
   endfunction

   function automatic logic signed [WORD_BITS-1:0] sat_word(
      input logic signed [ACC_BITS-1:0] v);
      logic signed [WORD_BITS-1:0] r;
      if (v[ACC_BITS-1:WORD_BITS-1] == '0 || v[ACC_BITS-1:WORD_BITS-1] == '1) begin
         r = v[WORD_BITS-1:0];
      end else if (v[ACC_BITS-1]) begin
         r = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== hdl/jse_ram.sv =====
module jse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/jse_mul.sv =====
module jse_mul (
   input  logic                                  clock,
   input  logic signed [jse_pkg::MUL_BITS-1:0]   op_a,
   input  logic signed [jse_pkg::MUL_BITS-1:0]   op_k,
   input  logic                                  op_neg,
   output logic signed [jse_pkg::TERM_BITS-1:0]  term
);

   // round(a * k / 2^30) half away from zero, optionally negated; the product and the rounded term are registered
   logic [jse_pkg::MUL_BITS-1:0] mag_a, mag_k;
   logic [63:0] prod_ff, prod_in;
   logic        sign_ff, sign_in;
   logic [63:0] rounded;
   logic signed [jse_pkg::TERM_BITS-1:0] term_ff, term_in;

   always_comb begin
      mag_a   = op_a[jse_pkg::MUL_BITS-1] ? -op_a : op_a;
      mag_k   = op_k[jse_pkg::MUL_BITS-1] ? -op_k : op_k;
      prod_in = 64'(mag_a[31:0]) * 64'(mag_k[31:0]);
      sign_in = op_a[jse_pkg::MUL_BITS-1] ^ op_k[jse_pkg::MUL_BITS-1] ^ op_neg;
      rounded = (prod_ff + (64'd1 << 29)) >> 30;
      term_in = sign_ff ? -$signed({1'b0, rounded[33:0]}) : $signed({1'b0, rounded[33:0]});
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sign_ff <= sign_in;
      term_ff <= term_in;
   end

   assign term = term_ff;

endmodule

// ===== hdl/jacobi_symmetric_eigensolver.sv =====
// Jacobi eigensolver. Load a symmetric Q8.24 matrix one element per transaction on req_;
// an element with req_last set starts a solve on a copy of the leading active_size block
// and the block takes no request until the last result has gone. Loading takes one element
// per cycle. A solve copies the matrix, then per rotation runs a pivot search, CORDIC through
// one shared shift-add unit, and the rotation through a single shared multiplier; output
// takes a square root per column before its results. Results come column by column.
module jacobi_symmetric_eigensolver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_row,
   input  logic [2:0]  req_col,
   input  logic signed [31:0] req_value,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_vector_index,
   output logic [2:0]  rsp_component_index,
   output logic signed [31:0] rsp_vector_entry,
   output logic [30:0] rsp_root_eigenvalue,
   output logic        rsp_final_entry,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data
);

   localparam int AB = jse_pkg::ADDR_BITS;
   localparam int WB = jse_pkg::WORD_BITS;

   jse_pkg::state_type state_ff, state_in;
   jse_pkg::phase_type phase_ff, phase_in;

   logic [3:0]  size_ff, size_in;
   logic [7:0]  limit_ff, limit_in;
   logic [30:0] stop_ff, stop_in;
   logic [7:0]  rot_ff, rot_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [3:0]  i_ff, i_in, j_ff, j_in;
   logic [1:0]  rd_ff, rd_in;
   logic [2:0]  t_ff, t_in;
   logic [4:0]  it_ff, it_in;
   logic [2:0]  p_ff, p_in, q_ff, q_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [31:0] best_ff, best_in;
   logic signed [WB-1:0] opa_ff, opa_in, opb_ff, opb_in, opc_ff, opc_in;
   logic signed [WB-1:0] c_ff, c_in, s_ff, s_in, cc_ff, cc_in, ss_ff, ss_in;
   logic signed [WB-1:0] cs2_ff, cs2_in;
   logic signed [jse_pkg::ACC_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [jse_pkg::ACC_BITS-1:0] acc0_ff, acc0_in, acc1_ff, acc1_in;
   logic signed [jse_pkg::ANG_BITS-1:0] cz_ff, cz_in;
   logic [31:0] rem_ff, rem_in;
   logic [27:0] root_ff, root_in;
   logic [55:0] rad_ff, rad_in;
   logic [2:0]  out_vec_ff, out_vec_in, out_comp_ff, out_comp_in;
   logic signed [WB-1:0] out_entry_ff, out_entry_in;
   logic        out_final_ff, out_final_in;

   logic          ld_we;
   logic [AB-1:0] ld_wa, ld_ra, a_wa, a_ra, v_wa, v_ra;
   logic [WB-1:0] ld_wd, ld_rd, a_wd, a_rd, v_wd, v_rd;
   logic          a_we, v_we;

   logic signed [jse_pkg::MUL_BITS-1:0]  mul_a, mul_k;
   logic                                 mul_neg;
   logic signed [jse_pkg::TERM_BITS-1:0] mul_term;

   logic [3:0]  n_eff;
   logic [2:0]  terms;
   logic [2:0]  res_idx;
   logic [31:0] mag;
   logic signed [32:0] diff, y2;
   logic signed [jse_pkg::ACC_BITS-1:0] dx36, sx, sy, xn, yn;
   logic signed [jse_pkg::ANG_BITS-1:0] zn;
   logic signed [jse_pkg::ACC_BITS-1:0] term_ext;
   logic [31:0] rem_sh, trial;
   logic signed [WB-1:0] res_x, res_y;

   jse_ram #(.WIDTH(WB), .DEPTH(jse_pkg::STORE_DEPTH)) u_load_ram (
      .clock(clock), .wr_en(ld_we), .wr_addr(ld_wa), .wr_data(ld_wd),
      .rd_addr(ld_ra), .rd_data(ld_rd));

   jse_ram #(.WIDTH(WB), .DEPTH(jse_pkg::STORE_DEPTH)) u_work_ram (
      .clock(clock), .wr_en(a_we), .wr_addr(a_wa), .wr_data(a_wd),
      .rd_addr(a_ra), .rd_data(a_rd));

   jse_ram #(.WIDTH(WB), .DEPTH(jse_pkg::STORE_DEPTH)) u_vector_ram (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(v_ra), .rd_data(v_rd));

   jse_mul u_mul (
      .clock(clock), .op_a(mul_a), .op_k(mul_k), .op_neg(mul_neg), .term(mul_term));

   assign req_ready = (state_ff == jse_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_vector_index    = out_vec_ff;
   assign rsp_component_index = out_comp_ff;
   assign rsp_vector_entry    = out_entry_ff;
   assign rsp_root_eigenvalue = {3'b000, root_ff};
   assign rsp_final_entry     = out_final_ff;

   always_comb begin
      if (size_ff == 4'd0) begin
         n_eff = 4'd1;
      end else if (size_ff > 4'(jse_pkg::MAX_SIZE)) begin
         n_eff = 4'(jse_pkg::MAX_SIZE);
      end else begin
         n_eff = size_ff;
      end
   end

   // multiplier operand schedule
   always_comb begin
      mul_a   = '0;
      mul_k   = '0;
      mul_neg = 1'b0;
      terms   = 3'd4;
      case (phase_ff)
         jse_pkg::PH_COEF: begin
            terms = 3'd3;
            case (t_ff)
               3'd0: begin mul_a = {c_ff[WB-1], c_ff}; mul_k = {c_ff[WB-1], c_ff}; end
               3'd1: begin mul_a = {s_ff[WB-1], s_ff}; mul_k = {s_ff[WB-1], s_ff}; end
               3'd2: begin mul_a = {c_ff, 1'b0};       mul_k = {s_ff[WB-1], s_ff}; end
               default: begin end
            endcase
         end
         jse_pkg::PH_DIAG: begin
            terms = 3'd6;
            case (t_ff)
               3'd0: begin mul_a = {opa_ff[WB-1], opa_ff}; mul_k = {cc_ff[WB-1], cc_ff}; end
               3'd1: begin mul_a = {opc_ff[WB-1], opc_ff}; mul_k = {cs2_ff[WB-1], cs2_ff}; end
               3'd2: begin mul_a = {opb_ff[WB-1], opb_ff}; mul_k = {ss_ff[WB-1], ss_ff}; end
               3'd3: begin mul_a = {opa_ff[WB-1], opa_ff}; mul_k = {ss_ff[WB-1], ss_ff}; end
               3'd4: begin
                  mul_a = {opc_ff[WB-1], opc_ff}; mul_k = {cs2_ff[WB-1], cs2_ff};
                  mul_neg = 1'b1;
               end
               3'd5: begin mul_a = {opb_ff[WB-1], opb_ff}; mul_k = {cc_ff[WB-1], cc_ff}; end
               default: begin end
            endcase
         end
         default: begin
            case (t_ff)
               3'd0: begin mul_a = {opa_ff[WB-1], opa_ff}; mul_k = {c_ff[WB-1], c_ff}; end
               3'd1: begin mul_a = {opb_ff[WB-1], opb_ff}; mul_k = {s_ff[WB-1], s_ff}; end
               3'd2: begin mul_a = {opb_ff[WB-1], opb_ff}; mul_k = {c_ff[WB-1], c_ff}; end
               3'd3: begin
                  mul_a = {opa_ff[WB-1], opa_ff}; mul_k = {s_ff[WB-1], s_ff};
                  mul_neg = 1'b1;
               end
               default: begin end
            endcase
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;  phase_in = phase_ff;
      size_in = size_ff;    limit_in = limit_ff;  stop_in = stop_ff;
      rot_in = rot_ff;      cnt_in = cnt_ff;      i_in = i_ff;  j_in = j_ff;
      rd_in = rd_ff;        t_in = t_ff;          it_in = it_ff;
      p_in = p_ff;          q_in = q_ff;          rsp_valid_in = rsp_valid_ff;
      best_in = best_ff;    opa_in = opa_ff;      opb_in = opb_ff;  opc_in = opc_ff;
      c_in = c_ff;  s_in = s_ff;  cc_in = cc_ff;  ss_in = ss_ff;  cs2_in = cs2_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;
      acc0_in = acc0_ff;  acc1_in = acc1_ff;
      rem_in = rem_ff;  root_in = root_ff;  rad_in = rad_ff;
      out_vec_in = out_vec_ff;  out_comp_in = out_comp_ff;
      out_entry_in = out_entry_ff;  out_final_in = out_final_ff;

      ld_we = 1'b0;  ld_wa = {req_row, req_col};  ld_wd = req_value;
      ld_ra = cnt_ff[AB-1:0];
      a_we = 1'b0;  a_wa = '0;  a_wd = '0;  a_ra = '0;
      v_we = 1'b0;  v_wa = '0;  v_wd = '0;  v_ra = '0;

      mag = a_rd[WB-1] ? (~a_rd + 32'd1) : a_rd;
      diff = $signed({opa_ff[WB-1], opa_ff}) - $signed({opb_ff[WB-1], opb_ff});
      y2 = {opc_ff, 1'b0};
      dx36 = jse_pkg::ACC_BITS'(diff);
      sx = cy_ff >>> it_ff;
      sy = cx_ff >>> it_ff;
      xn = cx_ff;  yn = cy_ff;  zn = cz_ff;
      res_idx = t_ff - 3'd2;
      term_ext = jse_pkg::ACC_BITS'(mul_term);
      rem_sh = {rem_ff[29:0], rad_ff[55:54]};
      trial = {2'b00, root_ff, 2'b01};
      res_x = jse_pkg::sat_word(acc0_ff);
      res_y = jse_pkg::sat_word(acc1_ff);

      if (csr_valid && csr_ready) begin
         case (csr_index)
            jse_pkg::CSR_ACTIVE_SIZE:    size_in  = csr_data[3:0];
            jse_pkg::CSR_ROTATION_LIMIT: limit_in = csr_data[7:0];
            jse_pkg::CSR_STOP_LEVEL:     stop_in  = csr_data;
            default: begin end
         endcase
      end

      case (state_ff)
         jse_pkg::ST_IDLE: begin
            if (req_valid) begin
               ld_we = 1'b1;
               if (req_last) begin
                  cnt_in = '0;
                  state_in = jse_pkg::ST_COPY;
               end
            end
         end
         jse_pkg::ST_COPY: begin
            if (cnt_ff != 7'(jse_pkg::STORE_DEPTH)) begin
               v_we = 1'b1;
               v_wa = cnt_ff[AB-1:0];
               v_wd = (cnt_ff[5:3] == cnt_ff[2:0]) ? jse_pkg::WORD_ONE : '0;
            end
            if (cnt_ff != '0) begin
               a_we = 1'b1;
               a_wa = AB'(cnt_ff - 7'd1);
               a_wd = ld_rd;
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(jse_pkg::STORE_DEPTH)) begin
               rot_in = '0;
               state_in = jse_pkg::ST_SRCH_INIT;
            end
         end
         jse_pkg::ST_SRCH_INIT: begin
            best_in = '0;  p_in = '0;  q_in = '0;  i_in = 4'd0;  j_in = 4'd1;
            if (rot_ff >= limit_ff) begin
               i_in = '0;  j_in = '0;  rd_in = '0;
               state_in = jse_pkg::ST_ROOT_RD;
            end else if (n_eff < 4'd2) begin
               state_in = jse_pkg::ST_DECIDE;
            end else begin
               state_in = jse_pkg::ST_SRCH_RD;
            end
         end
         jse_pkg::ST_SRCH_RD: begin
            a_ra = {i_ff[2:0], j_ff[2:0]};
            state_in = jse_pkg::ST_SRCH_CMP;
         end
         jse_pkg::ST_SRCH_CMP: begin
            if (mag > best_ff) begin
               best_in = mag;  p_in = i_ff[2:0];  q_in = j_ff[2:0];
            end
            if (j_ff + 4'd1 < n_eff) begin
               j_in = j_ff + 4'd1;
               state_in = jse_pkg::ST_SRCH_RD;
            end else if (i_ff + 4'd2 < n_eff) begin
               i_in = i_ff + 4'd1;
               j_in = i_ff + 4'd2;
               state_in = jse_pkg::ST_SRCH_RD;
            end else begin
               state_in = jse_pkg::ST_DECIDE;
            end
         end
         jse_pkg::ST_DECIDE: begin
            rd_in = '0;
            if (best_ff == '0 || best_ff < {1'b0, stop_ff}) begin
               i_in = '0;  j_in = '0;
               state_in = jse_pkg::ST_ROOT_RD;
            end else begin
               state_in = jse_pkg::ST_PIV_RD;
            end
         end
         jse_pkg::ST_PIV_RD: begin
            case (rd_ff)
               2'd0: a_ra = {p_ff, p_ff};
               2'd1: a_ra = {q_ff, q_ff};
               default: a_ra = {p_ff, q_ff};
            endcase
            if (rd_ff == 2'd1) opa_in = a_rd;
            if (rd_ff == 2'd2) opb_in = a_rd;
            rd_in = rd_ff + 2'd1;
            if (rd_ff == 2'd3) begin
               opc_in = a_rd;
               state_in = jse_pkg::ST_PIV_DEC;
            end
         end
         jse_pkg::ST_PIV_DEC: begin
            it_in = '0;
            if (diff == '0) begin
               cz_in = (opc_ff > 0) ? jse_pkg::ANGLE_QUARTER_PI : -jse_pkg::ANGLE_QUARTER_PI;
               cx_in = jse_pkg::CORDIC_GAIN_INV;
               cy_in = '0;
               state_in = jse_pkg::ST_ROTATE;
            end else begin
               if (diff < 0) begin
                  cx_in = -dx36;
                  cy_in = -jse_pkg::ACC_BITS'(y2);
                  cz_in = (y2 >= 0) ? jse_pkg::ANGLE_PI : -jse_pkg::ANGLE_PI;
               end else begin
                  cx_in = dx36;
                  cy_in = jse_pkg::ACC_BITS'(y2);
                  cz_in = '0;
               end
               state_in = jse_pkg::ST_VECTOR;
            end
         end
         jse_pkg::ST_VECTOR: begin
            if (!cy_ff[jse_pkg::ACC_BITS-1]) begin
               xn = cx_ff + sx;  yn = cy_ff - sy;  zn = cz_ff + jse_pkg::atan_step(it_ff);
            end else begin
               xn = cx_ff - sx;  yn = cy_ff + sy;  zn = cz_ff - jse_pkg::atan_step(it_ff);
            end
            cx_in = xn;  cy_in = yn;  cz_in = zn;
            it_in = it_ff + 5'd1;
            if (it_ff == 5'(jse_pkg::CORDIC_STEPS - 1)) begin
               cz_in = zn >>> 1;
               cx_in = jse_pkg::CORDIC_GAIN_INV;
               cy_in = '0;
               it_in = '0;
               state_in = jse_pkg::ST_ROTATE;
            end
         end
         jse_pkg::ST_ROTATE: begin
            if (!cz_ff[jse_pkg::ANG_BITS-1]) begin
               xn = cx_ff - sx;  yn = cy_ff + sy;  zn = cz_ff - jse_pkg::atan_step(it_ff);
            end else begin
               xn = cx_ff + sx;  yn = cy_ff - sy;  zn = cz_ff + jse_pkg::atan_step(it_ff);
            end
            cx_in = xn;  cy_in = yn;  cz_in = zn;
            it_in = it_ff + 5'd1;
            if (it_ff == 5'(jse_pkg::CORDIC_STEPS - 1)) begin
               c_in = xn[WB-1:0];
               s_in = yn[WB-1:0];
               phase_in = jse_pkg::PH_COEF;
               t_in = '0;
               state_in = jse_pkg::ST_MAC;
            end
         end
         jse_pkg::ST_MAC: begin
            if (t_ff == '0) begin
               acc0_in = '0;
               acc1_in = '0;
            end
            if (t_ff >= 3'd2) begin
               case (phase_ff)
                  jse_pkg::PH_COEF: begin
                     case (res_idx)
                        3'd0: cc_in = mul_term[WB-1:0];
                        3'd1: ss_in = mul_term[WB-1:0];
                        default: cs2_in = mul_term[WB-1:0];
                     endcase
                  end
                  jse_pkg::PH_DIAG: begin
                     if (res_idx < 3'd3) acc0_in = acc0_ff + term_ext;
                     else acc1_in = acc1_ff + term_ext;
                  end
                  default: begin
                     if (res_idx < 3'd2) acc0_in = acc0_ff + term_ext;
                     else acc1_in = acc1_ff + term_ext;
                  end
               endcase
            end
            t_in = t_ff + 3'd1;
            if (t_ff == terms + 3'd1) begin
               t_in = '0;
               rd_in = '0;
               case (phase_ff)
                  jse_pkg::PH_COEF: phase_in = jse_pkg::PH_DIAG;
                  jse_pkg::PH_DIAG: state_in = jse_pkg::ST_DIAG_WR;
                  jse_pkg::PH_OFF:  state_in = jse_pkg::ST_OFF_WR;
                  default:          state_in = jse_pkg::ST_VEC_WR;
               endcase
            end
         end
         jse_pkg::ST_DIAG_WR: begin
            a_we = 1'b1;
            case (rd_ff)
               2'd0: begin a_wa = {p_ff, p_ff}; a_wd = res_x; end
               2'd1: begin a_wa = {q_ff, q_ff}; a_wd = res_y; end
               2'd2: begin a_wa = {p_ff, q_ff}; a_wd = '0; end
               default: begin a_wa = {q_ff, p_ff}; a_wd = '0; end
            endcase
            rd_in = rd_ff + 2'd1;
            if (rd_ff == 2'd3) begin
               i_in = '0;
               state_in = jse_pkg::ST_OFF_NEXT;
            end
         end
         jse_pkg::ST_OFF_NEXT: begin
            rd_in = '0;
            if (i_ff == n_eff) begin
               i_in = '0;
               state_in = jse_pkg::ST_VEC_NEXT;
            end else if (i_ff[2:0] == p_ff || i_ff[2:0] == q_ff) begin
               i_in = i_ff + 4'd1;
            end else begin
               state_in = jse_pkg::ST_OFF_RD;
            end
         end
         jse_pkg::ST_OFF_RD: begin
            a_ra = (rd_ff == 2'd0) ? {i_ff[2:0], p_ff} : {i_ff[2:0], q_ff};
            rd_in = rd_ff + 2'd1;
            if (rd_ff == 2'd1) opa_in = a_rd;
            if (rd_ff == 2'd2) begin
               opb_in = a_rd;
               phase_in = jse_pkg::PH_OFF;
               t_in = '0;
               state_in = jse_pkg::ST_MAC;
            end
         end
         jse_pkg::ST_OFF_WR: begin
            a_we = 1'b1;
            case (rd_ff)
               2'd0: begin a_wa = {i_ff[2:0], p_ff}; a_wd = res_x; end
               2'd1: begin a_wa = {p_ff, i_ff[2:0]}; a_wd = res_x; end
               2'd2: begin a_wa = {i_ff[2:0], q_ff}; a_wd = res_y; end
               default: begin a_wa = {q_ff, i_ff[2:0]}; a_wd = res_y; end
            endcase
            rd_in = rd_ff + 2'd1;
            if (rd_ff == 2'd3) begin
               i_in = i_ff + 4'd1;
               state_in = jse_pkg::ST_OFF_NEXT;
            end
         end
         jse_pkg::ST_VEC_NEXT: begin
            rd_in = '0;
            if (i_ff == n_eff) begin
               rot_in = rot_ff + 8'd1;
               state_in = jse_pkg::ST_SRCH_INIT;
            end else begin
               state_in = jse_pkg::ST_VEC_RD;
            end
         end
         jse_pkg::ST_VEC_RD: begin
            v_ra = (rd_ff == 2'd0) ? {i_ff[2:0], p_ff} : {i_ff[2:0], q_ff};
            rd_in = rd_ff + 2'd1;
            if (rd_ff == 2'd1) opa_in = v_rd;
            if (rd_ff == 2'd2) begin
               opb_in = v_rd;
               phase_in = jse_pkg::PH_VEC;
               t_in = '0;
               state_in = jse_pkg::ST_MAC;
            end
         end
         jse_pkg::ST_VEC_WR: begin
            v_we = 1'b1;
            if (rd_ff == 2'd0) begin
               v_wa = {i_ff[2:0], p_ff};
               v_wd = res_x;
               rd_in = 2'd1;
            end else begin
               v_wa = {i_ff[2:0], q_ff};
               v_wd = res_y;
               i_in = i_ff + 4'd1;
               state_in = jse_pkg::ST_VEC_NEXT;
            end
         end
         jse_pkg::ST_ROOT_RD: begin
            a_ra = {j_ff[2:0], j_ff[2:0]};
            if (rd_ff == 2'd0) begin
               rd_in = 2'd1;
            end else begin
               rd_in = '0;
               i_in = '0;
               rem_in = '0;
               root_in = '0;
               it_in = '0;
               rad_in = {1'b0, a_rd[WB-2:0], {jse_pkg::FRAC_BITS{1'b0}}};
               if (a_rd[WB-1] || a_rd == '0) begin
                  state_in = jse_pkg::ST_OUT_RD;
               end else begin
                  state_in = jse_pkg::ST_ROOT_RUN;
               end
            end
         end
         jse_pkg::ST_ROOT_RUN: begin
            rad_in = {rad_ff[53:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               root_in = {root_ff[26:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               root_in = {root_ff[26:0], 1'b0};
            end
            it_in = it_ff + 5'd1;
            if (it_ff == 5'(jse_pkg::ROOT_STEPS - 1)) begin
               rd_in = '0;
               state_in = jse_pkg::ST_OUT_RD;
            end
         end
         jse_pkg::ST_OUT_RD: begin
            v_ra = {i_ff[2:0], j_ff[2:0]};
            if (rd_ff == 2'd0) begin
               rd_in = 2'd1;
            end else begin
               out_vec_in = j_ff[2:0];
               out_comp_in = i_ff[2:0];
               out_entry_in = v_rd;
               out_final_in = (i_ff + 4'd1 == n_eff) && (j_ff + 4'd1 == n_eff);
               rsp_valid_in = 1'b1;
               state_in = jse_pkg::ST_OUT_SEND;
            end
         end
         jse_pkg::ST_OUT_SEND: begin
            rd_in = '0;
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (i_ff + 4'd1 < n_eff) begin
                  i_in = i_ff + 4'd1;
                  state_in = jse_pkg::ST_OUT_RD;
               end else if (j_ff + 4'd1 < n_eff) begin
                  j_in = j_ff + 4'd1;
                  state_in = jse_pkg::ST_ROOT_RD;
               end else begin
                  state_in = jse_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = jse_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jse_pkg::ST_IDLE;
         phase_ff     <= jse_pkg::PH_COEF;
         size_ff      <= 4'd8;
         limit_ff     <= 8'd50;
         stop_ff      <= 31'd1;
         rot_ff       <= '0;
         cnt_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rd_ff        <= '0;
         t_ff         <= '0;
         it_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         size_ff      <= size_in;
         limit_ff     <= limit_in;
         stop_ff      <= stop_in;
         rot_ff       <= rot_in;
         cnt_ff       <= cnt_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rd_ff        <= rd_in;
         t_ff         <= t_in;
         it_ff        <= it_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;  q_ff <= q_in;  best_ff <= best_in;
      opa_ff <= opa_in;  opb_ff <= opb_in;  opc_ff <= opc_in;
      c_ff <= c_in;  s_ff <= s_in;  cc_ff <= cc_in;  ss_ff <= ss_in;  cs2_ff <= cs2_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  cz_ff <= cz_in;
      acc0_ff <= acc0_in;  acc1_ff <= acc1_in;
      rem_ff <= rem_in;  root_ff <= root_in;  rad_ff <= rad_in;
      out_vec_ff <= out_vec_in;  out_comp_ff <= out_comp_in;
      out_entry_ff <= out_entry_in;  out_final_ff <= out_final_in;
   end

endmodule
